>>> hw/rtl/bis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_pkg
// Shared sizes and constants of the bilinear image scaler.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 8;

  localparam int COORD_W = 11;
  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int DIM_W   = 9;
  localparam int SCALE_W = 10;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;

  // percent constant 100 fits in 7 bits
  localparam int PCT      = 100;
  localparam int PCT_W    = 7;
  localparam int NUM_W    = COORD_W + PCT_W + FRAC_BITS;
  localparam int INT_W    = NUM_W - FRAC_BITS;
  localparam int WGT_W    = 2 * FRAC_BITS + 1;
  localparam int ACC_W    = CH_W + 2 * FRAC_BITS;
  localparam int ONE_W    = FRAC_BITS + 1;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 2'd2;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_PIX  = 1'b1;

  // effective source size: zero counts as one, large values saturate
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/bis_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bis_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/bis_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_div
// Restoring divider, one quotient bit per cycle, for the coordinate mapping.
// ----------------------------------------------------------------------------
module bis_div
  import bis_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NUM_W-1:0]   num_i,
  input  logic [SCALE_W-1:0] den_i,
  output logic               done_o,
  output logic [NUM_W-1:0]   quot_o
);

  localparam int CNT_W = $clog2(NUM_W);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [NUM_W-1:0]   work_q, work_d;
  logic [SCALE_W-1:0] rem_q, rem_d;
  logic [SCALE_W-1:0] den_q, den_d;
  logic [SCALE_W:0]   rem_sh;
  logic [SCALE_W:0]   diff;
  logic               qbit;

  assign rem_sh = {rem_q, work_q[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign qbit   = (rem_sh >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    work_d = work_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      work_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      work_d = {work_q[NUM_W-2:0], qbit};
      rem_d  = qbit ? diff[SCALE_W-1:0] : rem_sh[SCALE_W-1:0];
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = work_q;

endmodule

>>> hw/rtl/bilinear_image_scaler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_scaler_core
// Bilinear RGB scaler around a 24-bit frame store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries loads and pixel requests.
//   A load writes one source pixel into the frame store in the cycle it is
//   transferred; loads outside the configured source size are dropped. A load
//   gives no result and the block takes the next item in the following cycle.
//   A request maps its destination coordinate to a source position through two
//   restoring dividers (NUM_W = 26 quotient bits, one per cycle), builds the
//   four weights, reads the four neighbours from the single frame store read
//   port while blending and hands the pixel to the output register. A position
//   outside the source skips the weights and the reads. The block takes no new
//   item until the finished request has moved into the output register.
//   Output channel (out_valid_o / out_stall_i) is one register deep; a stalled
//   result holds while loads keep flowing in. A finished request waits until
//   the output register is free.
//   Reset returns the size and scale registers to 256, 256 and 100; the frame
//   store content is undefined until loaded. Write configuration only idle.
// ----------------------------------------------------------------------------
module bilinear_image_scaler_core
  import bis_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic [COORD_W-1:0]   coord_x_i,
  input  logic [COORD_W-1:0]   coord_y_i,
  input  logic [CH_W-1:0]      blue_in_i,
  input  logic [CH_W-1:0]      green_in_i,
  input  logic [CH_W-1:0]      red_in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CH_W-1:0]      blue_out_o,
  output logic [CH_W-1:0]      green_out_o,
  output logic [CH_W-1:0]      red_out_o,
  output logic                 outside_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_WGT  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam logic [ONE_W-1:0] ONE = ONE_W'(1 << FRAC_BITS);

  // configuration
  logic [DIM_W-1:0]   width_q, height_q;
  logic [SCALE_W-1:0] scale_q;
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [SCALE_W-1:0] scl_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(256);
      height_q <= DIM_W'(256);
      scale_q  <= SCALE_W'(100);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SRC_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_SRC_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
        CFG_SCALE:      scale_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign w_eff   = clamp_dim(width_q, DIM_W'(MAX_WIDTH));
  assign h_eff   = clamp_dim(height_q, DIM_W'(MAX_HEIGHT));
  assign scl_eff = (scale_q == '0) ? SCALE_W'(1) : scale_q;

  // control
  logic [2:0] state_q, state_d;
  logic       in_xfer, out_xfer;
  logic       load_in_range;
  logic       ram_we, ram_re;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_o && !out_stall_i;

  assign load_in_range = ({{(COORD_W-DIM_W){1'b0}}, w_eff} > coord_x_i) &&
                         ({{(COORD_W-DIM_W){1'b0}}, h_eff} > coord_y_i);
  assign ram_we = in_xfer && (req_type_i == REQ_LOAD) && load_in_range;

  // coordinate mapping
  logic                   div_start, div_done;
  logic                   div_y_done;
  logic [NUM_W-1:0]       num_x, num_y, qx, qy;
  logic [COORD_W+PCT_W-1:0] px_pct, py_pct;

  assign div_start = in_xfer && (req_type_i == REQ_PIX);
  assign px_pct = (COORD_W+PCT_W)'(coord_x_i) * (COORD_W+PCT_W)'(PCT);
  assign py_pct = (COORD_W+PCT_W)'(coord_y_i) * (COORD_W+PCT_W)'(PCT);
  assign num_x  = {px_pct, {FRAC_BITS{1'b0}}};
  assign num_y  = {py_pct, {FRAC_BITS{1'b0}}};

  bis_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_x),
    .den_i   (scl_eff),
    .done_o  (div_done),
    .quot_o  (qx)
  );

  bis_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_y),
    .den_i   (scl_eff),
    .done_o  (div_y_done),
    .quot_o  (qy)
  );

  logic [INT_W-1:0] int_x, int_y;
  logic             map_outside;
  logic [DIM_W-1:0] ix_inc, iy_inc;
  logic [COL_W-1:0] ix_nxt;
  logic [ROW_W-1:0] iy_nxt;

  assign int_x = qx[NUM_W-1:FRAC_BITS];
  assign int_y = qy[NUM_W-1:FRAC_BITS];
  assign map_outside = (int_x >= INT_W'(w_eff)) || (int_y >= INT_W'(h_eff));

  assign ix_inc = DIM_W'(int_x[COL_W-1:0]) + DIM_W'(1);
  assign iy_inc = DIM_W'(int_y[ROW_W-1:0]) + DIM_W'(1);
  assign ix_nxt = (ix_inc < w_eff) ? ix_inc[COL_W-1:0] :
                  COL_W'(w_eff - DIM_W'(1));
  assign iy_nxt = (iy_inc < h_eff) ? iy_inc[ROW_W-1:0] :
                  ROW_W'(h_eff - DIM_W'(1));

  // neighbour positions and fractions
  logic [COL_W-1:0]     ix_q, ix1_q;
  logic [ROW_W-1:0]     iy_q, iy1_q;
  logic [FRAC_BITS-1:0] fx_q, fy_q;
  logic                 outside_q;

  // weights, order: upper left, upper right, lower left, lower right
  logic [WGT_W-1:0]   wgt_q [4];
  logic [ONE_W-1:0]   ifx, ify, ffx, ffy;
  logic [2*ONE_W-1:0] w00_p, w01_p, w10_p, w11_p;

  assign ffx = ONE_W'(fx_q);
  assign ffy = ONE_W'(fy_q);
  assign ifx = ONE - ffx;
  assign ify = ONE - ffy;
  assign w00_p = ifx * ify;
  assign w01_p = ffx * ify;
  assign w10_p = ifx * ffy;
  assign w11_p = ffx * ffy;

  // read sequence: each step issues one address and blends the registered read data of the address issued before it
  logic [2:0]        cnt_q, cnt_d;
  logic [1:0]        acc_idx;
  logic [ADDR_W-1:0] raddr;
  logic [PIX_W-1:0]  rdata;
  logic [ACC_W-1:0]  acc_q [3];
  logic [ACC_W-1:0]  acc_d [3];
  logic [CH_W+WGT_W-1:0] prod [3];

  assign ram_re  = (state_q == ST_RD) && !cnt_q[2];
  assign acc_idx = cnt_q[1:0] - 2'd1;

  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    raddr = {iy_q, ix_q};
      2'd1:    raddr = {iy_q, ix1_q};
      2'd2:    raddr = {iy1_q, ix_q};
      default: raddr = {iy1_q, ix1_q};
    endcase
  end

  bis_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ({coord_y_i[ROW_W-1:0], coord_x_i[COL_W-1:0]}),
    .wdata_i ({red_in_i, green_in_i, blue_in_i}),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c]  = (CH_W+WGT_W)'(rdata[c*CH_W +: CH_W]) * (CH_W+WGT_W)'(wgt_q[acc_idx]);
      acc_d[c] = acc_q[c];
      if (state_q == ST_WGT) begin
        acc_d[c] = '0;
      end else if (state_q == ST_RD && cnt_q != 3'd0) begin
        acc_d[c] = acc_q[c] + prod[c][ACC_W-1:0];
      end
    end
  end

  // output register
  logic            out_valid_q, out_valid_d;
  logic            res_load;
  logic [CH_W-1:0] blue_q, green_q, red_q;
  logic            res_outside_q;

  assign res_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (div_start) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = map_outside ? ST_FIN : ST_WGT;
        end
      end
      ST_WGT: begin
        cnt_d   = '0;
        state_d = ST_RD;
      end
      ST_RD: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          cnt_d   = '0;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (res_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_xfer) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV && div_done) begin
      outside_q <= map_outside;
      ix_q      <= int_x[COL_W-1:0];
      iy_q      <= int_y[ROW_W-1:0];
      ix1_q     <= ix_nxt;
      iy1_q     <= iy_nxt;
      fx_q      <= qx[FRAC_BITS-1:0];
      fy_q      <= qy[FRAC_BITS-1:0];
    end
    if (state_q == ST_WGT) begin
      wgt_q[0] <= w00_p[WGT_W-1:0];
      wgt_q[1] <= w01_p[WGT_W-1:0];
      wgt_q[2] <= w10_p[WGT_W-1:0];
      wgt_q[3] <= w11_p[WGT_W-1:0];
    end
    for (int c = 0; c < 3; c++) begin
      acc_q[c] <= acc_d[c];
    end
    if (res_load) begin
      res_outside_q <= outside_q;
      blue_q  <= outside_q ? '0 : acc_q[0][ACC_W-1 -: CH_W];
      green_q <= outside_q ? '0 : acc_q[1][ACC_W-1 -: CH_W];
      red_q   <= outside_q ? '0 : acc_q[2][ACC_W-1 -: CH_W];
    end
  end

  assign out_valid_o = out_valid_q;
  assign blue_out_o  = blue_q;
  assign green_out_o = green_q;
  assign red_out_o   = red_q;
  assign outside_o   = res_outside_q;

  // checks
  a_write_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_IDLE))
    else $error("frame store written while a request is in flight");

  a_no_read_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("frame store read and write in the same cycle");

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done == div_y_done)
    else $error("coordinate dividers out of step");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the mapping phase");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && outside_o) |->
      (blue_out_o == '0 && green_out_o == '0 && red_out_o == '0))
    else $error("outside result carries nonzero channels");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_valid_o && out_stall_i) |=> (state_q == ST_FIN))
    else $error("finished request left while output register full");

endmodule

>>> tb/bilinear_image_scaler_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_scaler_core_test
// Self-checking bench for the bilinear scaler: loads source pixels, requests
// destination pixels under many size/scale settings and compares every result
// with a predictor that holds its own copy of the frame store and registers.
// ----------------------------------------------------------------------------
module bilinear_image_scaler_core_test
  import bis_pkg::*;
();

  localparam int RAND_ITEMS   = 450;
  localparam int MIX_ITEMS    = 30;
  localparam int BLOCK_MAX    = 8;
  localparam int DRAIN_CYCLES = 60;
  localparam int QUIET_LIMIT  = 3000;
  localparam int CALM_FROM    = 150;
  localparam int CALM_TO      = 260;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic            outside;
  } pix_result_t;

  typedef struct packed {
    logic                 beyond;
    logic [DIM_W-1:0]     col0;
    logic [DIM_W-1:0]     col1;
    logic [DIM_W-1:0]     row0;
    logic [DIM_W-1:0]     row1;
    logic [FRAC_BITS-1:0] frac_x;
    logic [FRAC_BITS-1:0] frac_y;
  } src_pos_t;

  typedef enum logic [1:0] {STEP_CFG, STEP_LOAD, STEP_PIX} step_kind_e;

  typedef struct packed {
    step_kind_e         kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CH_W-1:0]    b;
    logic [CH_W-1:0]    g;
    logic [CH_W-1:0]    r;
    logic               known;
    pix_result_t        want;
    logic [DIM_W-1:0]   cfg_w;
    logic [DIM_W-1:0]   cfg_h;
    logic [SCALE_W-1:0] cfg_s;
  } stim_row_t;

  localparam pix_result_t PIX_OUTSIDE = {8'd0, 8'd0, 8'd0, 1'b1};

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 req_type_i;
  logic [COORD_W-1:0]   coord_x_i;
  logic [COORD_W-1:0]   coord_y_i;
  logic [CH_W-1:0]      blue_in_i;
  logic [CH_W-1:0]      green_in_i;
  logic [CH_W-1:0]      red_in_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [CH_W-1:0]      blue_out_o;
  logic [CH_W-1:0]      green_out_o;
  logic [CH_W-1:0]      red_out_o;
  logic                 outside_o;

  bilinear_image_scaler_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .coord_x_i   (coord_x_i),
    .coord_y_i   (coord_y_i),
    .blue_in_i   (blue_in_i),
    .green_in_i  (green_in_i),
    .red_in_i    (red_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .blue_out_o  (blue_out_o),
    .green_out_o (green_out_o),
    .red_out_o   (red_out_o),
    .outside_o   (outside_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [PIX_W-1:0]   src_image [DEPTH];
  bit                 src_written [DEPTH];
  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;
  logic [SCALE_W-1:0] scale_reg;

  pix_result_t pending_pixels [$];
  stim_row_t   directed_rows [$];

  int  errors;
  int  n_loads;
  int  n_dropped;
  int  n_requests;
  int  n_outside;
  int  n_settings;
  int  quiet_cycles;
  bit  calm;

  function automatic int eff_dim(input logic [DIM_W-1:0] v, input int maxv);
    if (v == '0) begin
      return 1;
    end
    return (v > maxv) ? maxv : int'(v);
  endfunction

  function automatic int store_addr(input int row, input int col);
    return (row * MAX_WIDTH + col) % DEPTH;
  endfunction

  function automatic src_pos_t map_to_source(input logic [COORD_W-1:0] x,
                                             input logic [COORD_W-1:0] y);
    src_pos_t        p;
    longint unsigned pos_x;
    longint unsigned pos_y;
    longint unsigned w;
    longint unsigned h;
    longint unsigned s;
    w = eff_dim(width_reg, MAX_WIDTH);
    h = eff_dim(height_reg, MAX_HEIGHT);
    s = (scale_reg == '0) ? 1 : scale_reg;
    pos_x = x;
    pos_y = y;
    pos_x = ((pos_x << FRAC_BITS) * PCT) / s;
    pos_y = ((pos_y << FRAC_BITS) * PCT) / s;
    p = '0;
    p.beyond = ((pos_x >> FRAC_BITS) >= w) || ((pos_y >> FRAC_BITS) >= h);
    if (!p.beyond) begin
      p.col0   = DIM_W'(pos_x >> FRAC_BITS);
      p.row0   = DIM_W'(pos_y >> FRAC_BITS);
      // right and lower neighbours stop at the last column and row
      p.col1   = DIM_W'((p.col0 + 1 < w) ? p.col0 + 1 : w - 1);
      p.row1   = DIM_W'((p.row0 + 1 < h) ? p.row0 + 1 : h - 1);
      p.frac_x = FRAC_BITS'(pos_x % (64'd1 << FRAC_BITS));
      p.frac_y = FRAC_BITS'(pos_y % (64'd1 << FRAC_BITS));
    end
    return p;
  endfunction

  // true when the request reads only loaded entries, or reads none at all
  function automatic bit pixel_ready(input logic [COORD_W-1:0] x,
                                     input logic [COORD_W-1:0] y);
    src_pos_t p;
    p = map_to_source(x, y);
    if (p.beyond) begin
      return 1'b1;
    end
    return src_written[store_addr(p.row0, p.col0)] && src_written[store_addr(p.row0, p.col1)]
        && src_written[store_addr(p.row1, p.col0)] && src_written[store_addr(p.row1, p.col1)];
  endfunction

  function automatic pix_result_t blend_pixel(input logic [COORD_W-1:0] x,
                                              input logic [COORD_W-1:0] y);
    src_pos_t         p;
    pix_result_t      res;
    logic [PIX_W-1:0] c00;
    logic [PIX_W-1:0] c01;
    logic [PIX_W-1:0] c10;
    logic [PIX_W-1:0] c11;
    logic [PIX_W-1:0] mix;
    longint unsigned  one;
    longint unsigned  w00;
    longint unsigned  w01;
    longint unsigned  w10;
    longint unsigned  w11;
    longint unsigned  acc;
    int               ch;
    p = map_to_source(x, y);
    res = '0;
    if (p.beyond) begin
      res.outside = 1'b1;
    end else begin
      c00 = src_image[store_addr(p.row0, p.col0)];
      c01 = src_image[store_addr(p.row0, p.col1)];
      c10 = src_image[store_addr(p.row1, p.col0)];
      c11 = src_image[store_addr(p.row1, p.col1)];
      one = 64'd1 << FRAC_BITS;
      w00 = (one - p.frac_x) * (one - p.frac_y);
      w01 = longint'(p.frac_x) * (one - p.frac_y);
      w10 = (one - p.frac_x) * p.frac_y;
      w11 = longint'(p.frac_x) * p.frac_y;
      for (ch = 0; ch < 3; ch++) begin
        acc = c00[ch*CH_W +: CH_W] * w00 + c01[ch*CH_W +: CH_W] * w01
            + c10[ch*CH_W +: CH_W] * w10 + c11[ch*CH_W +: CH_W] * w11;
        mix[ch*CH_W +: CH_W] = CH_W'(acc >> (2 * FRAC_BITS));
      end
      res.blue  = mix[0 +: CH_W];
      res.green = mix[CH_W +: CH_W];
      res.red   = mix[2*CH_W +: CH_W];
    end
    return res;
  endfunction

  function automatic stim_row_t load_row(input int x, input int y,
                                         input int b, input int g, input int r);
    stim_row_t row;
    row = '0;
    row.kind = STEP_LOAD;
    row.x = COORD_W'(x);
    row.y = COORD_W'(y);
    row.b = CH_W'(b);
    row.g = CH_W'(g);
    row.r = CH_W'(r);
    return row;
  endfunction

  function automatic stim_row_t pix_row(input int x, input int y, input logic known,
                                        input pix_result_t want);
    stim_row_t row;
    row = '0;
    row.kind  = STEP_PIX;
    row.x     = COORD_W'(x);
    row.y     = COORD_W'(y);
    row.known = known;
    row.want  = want;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input int w, input int h, input int s);
    stim_row_t row;
    row = '0;
    row.kind  = STEP_CFG;
    row.cfg_w = DIM_W'(w);
    row.cfg_h = DIM_W'(h);
    row.cfg_s = SCALE_W'(s);
    return row;
  endfunction

  // drive one item and hold it until the transfer; then update the predictor
  task automatic send_item(input logic kind, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic [CH_W-1:0] b,
                           input logic [CH_W-1:0] g, input logic [CH_W-1:0] r,
                           input logic known, input pix_result_t want);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 12) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    req_type_i = kind;
    coord_x_i  = x;
    coord_y_i  = y;
    blue_in_i  = b;
    green_in_i = g;
    red_in_i   = r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (kind == REQ_LOAD) begin
      if (x < eff_dim(width_reg, MAX_WIDTH) && y < eff_dim(height_reg, MAX_HEIGHT)) begin
        src_image[store_addr(y, x)]   = {r, g, b};
        src_written[store_addr(y, x)] = 1'b1;
        n_loads++;
      end else begin
        n_dropped++;
      end
    end else begin
      pending_pixels.push_back(known ? want : blend_pixel(x, y));
      n_requests++;
    end
  endtask

  // wait for the block to go idle, then write all three registers
  task automatic set_config(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                            input logic [SCALE_W-1:0] s);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = CFG_SRC_WIDTH;
    cfg_data_i  = CFG_DAT_W'(w);
    @(negedge clk_i);
    cfg_index_i = CFG_SRC_HEIGHT;
    cfg_data_i  = CFG_DAT_W'(h);
    @(negedge clk_i);
    cfg_index_i = CFG_SCALE;
    cfg_data_i  = CFG_DAT_W'(s);
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    width_reg  = w;
    height_reg = h;
    scale_reg  = s;
    n_settings++;
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 12);
  end

  always @(posedge clk_i) begin
    pix_result_t want;
    pix_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {blue_out_o, green_out_o, red_out_o, outside_o};
      if (pending_pixels.size() == 0) begin
        $error("result transfer with no request pending");
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (got.blue != want.blue) begin
          $error("blue_out: expected %0d, got %0d", want.blue, got.blue);
          errors++;
        end
        if (got.green != want.green) begin
          $error("green_out: expected %0d, got %0d", want.green, got.green);
          errors++;
        end
        if (got.red != want.red) begin
          $error("red_out: expected %0d, got %0d", want.red, got.red);
          errors++;
        end
        if (got.outside != want.outside) begin
          $error("outside: expected %0d, got %0d", want.outside, got.outside);
          errors++;
        end
        if (got.outside) begin
          n_outside++;
        end
      end
    end
  end

  // end the run when no transfer happens on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int                 phase;
    int                 base_work;
    int                 rand_done;
    int                 tries;
    int                 blk_w;
    int                 blk_h;
    int                 ext_x;
    int                 ext_y;
    int                 eff_s;
    int                 pick;
    bit                 found;
    logic [DIM_W-1:0]   pw;
    logic [DIM_W-1:0]   ph;
    logic [SCALE_W-1:0] ps;
    logic [COORD_W-1:0] rx;
    logic [COORD_W-1:0] ry;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_SRC_WIDTH;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_LOAD;
    coord_x_i   = '0;
    coord_y_i   = '0;
    blue_in_i   = '0;
    green_in_i  = '0;
    red_in_i    = '0;
    out_stall_i = 1'b0;
    width_reg   = 9'd256;
    height_reg  = 9'd256;
    scale_reg   = 10'd100;
    calm        = 1'b0;
    errors      = 0;
    n_loads     = 0;
    n_dropped   = 0;
    n_requests  = 0;
    n_outside   = 0;
    n_settings  = 0;

    // reset values: 256 x 256 source, unit scale
    directed_rows.push_back(load_row(0, 0, 255, 0, 128));
    directed_rows.push_back(load_row(1, 0, 0, 255, 1));
    directed_rows.push_back(load_row(0, 1, 10, 20, 30));
    directed_rows.push_back(load_row(1, 1, 40, 50, 60));
    directed_rows.push_back(load_row(0, 2, 70, 80, 90));
    directed_rows.push_back(load_row(1, 2, 100, 110, 120));
    directed_rows.push_back(pix_row(0, 0, 1'b1, {8'd255, 8'd0, 8'd128, 1'b0}));
    directed_rows.push_back(load_row(255, 255, 255, 255, 255));
    directed_rows.push_back(pix_row(255, 255, 1'b1, {8'd255, 8'd255, 8'd255, 1'b0}));
    directed_rows.push_back(pix_row(256, 0, 1'b1, PIX_OUTSIDE));
    directed_rows.push_back(pix_row(2047, 2047, 1'b1, PIX_OUTSIDE));
    // loads beyond the source size must not alias onto loaded entries
    directed_rows.push_back(load_row(256, 0, 1, 2, 3));
    directed_rows.push_back(load_row(2047, 2047, 7, 7, 7));
    directed_rows.push_back(pix_row(0, 1, 1'b1, {8'd10, 8'd20, 8'd30, 1'b0}));
    // an 800 percent upscale gives fractional weights
    directed_rows.push_back(cfg_row(256, 256, 800));
    directed_rows.push_back(pix_row(1, 1, 1'b0, '0));
    directed_rows.push_back(pix_row(7, 3, 1'b0, '0));
    // one-pixel source: every neighbour clamps onto the single entry
    directed_rows.push_back(cfg_row(1, 1, 800));
    directed_rows.push_back(pix_row(0, 0, 1'b1, {8'd255, 8'd0, 8'd128, 1'b0}));
    directed_rows.push_back(pix_row(7, 7, 1'b0, '0));
    directed_rows.push_back(pix_row(8, 0, 1'b1, PIX_OUTSIDE));
    // zero sizes and zero scale behave as one
    directed_rows.push_back(cfg_row(0, 0, 0));
    directed_rows.push_back(pix_row(0, 0, 1'b1, {8'd255, 8'd0, 8'd128, 1'b0}));
    directed_rows.push_back(pix_row(1, 0, 1'b1, PIX_OUTSIDE));
    // oversized registers saturate at the frame store size
    directed_rows.push_back(cfg_row(511, 300, 100));
    directed_rows.push_back(pix_row(255, 255, 1'b1, {8'd255, 8'd255, 8'd255, 1'b0}));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        STEP_CFG: begin
          set_config(directed_rows[i].cfg_w, directed_rows[i].cfg_h, directed_rows[i].cfg_s);
        end
        STEP_LOAD: begin
          send_item(REQ_LOAD, directed_rows[i].x, directed_rows[i].y, directed_rows[i].b,
                    directed_rows[i].g, directed_rows[i].r, 1'b0, '0);
        end
        default: begin
          send_item(REQ_PIX, directed_rows[i].x, directed_rows[i].y, '0, '0, '0,
                    directed_rows[i].known, directed_rows[i].want);
        end
      endcase
    end

    base_work = n_loads + n_requests;
    rand_done = 0;
    phase = 0;
    while (rand_done < RAND_ITEMS) begin
      case (phase)
        0: begin pw = 9'd256; ph = 9'd256; ps = 10'd800;  end
        1: begin pw = 9'd511; ph = 9'd511; ps = 10'd1023; end
        2: begin pw = 9'd1;   ph = 9'd1;   ps = 10'd1;    end
        3: begin pw = 9'd0;   ph = 9'd0;   ps = 10'd0;    end
        4: begin pw = 9'd8;   ph = 9'd8;   ps = 10'd100;  end
        default: begin
          pw = DIM_W'(($urandom_range(0, 99) < 85) ? $urandom_range(1, 8)
                                                   : $urandom_range(9, 511));
          ph = DIM_W'(($urandom_range(0, 99) < 85) ? $urandom_range(1, 8)
                                                   : $urandom_range(9, 511));
          pick = $urandom_range(0, 99);
          if (pick < 10) begin
            ps = SCALE_W'($urandom_range(1, 99));
          end else if (pick < 70) begin
            ps = SCALE_W'($urandom_range(100, 400));
          end else begin
            ps = SCALE_W'($urandom_range(401, 800));
          end
        end
      endcase
      set_config(pw, ph, ps);
      eff_s = (scale_reg == '0) ? 1 : scale_reg;
      blk_w = eff_dim(width_reg, MAX_WIDTH);
      blk_h = eff_dim(height_reg, MAX_HEIGHT);
      // large sources: load only a corner block and aim requests at it
      if (blk_w > BLOCK_MAX) begin
        blk_w = $urandom_range(2, BLOCK_MAX);
      end
      if (blk_h > BLOCK_MAX) begin
        blk_h = $urandom_range(2, BLOCK_MAX);
      end
      ext_x = (blk_w * eff_s) / PCT + 2;
      ext_y = (blk_h * eff_s) / PCT + 2;
      if (ext_x > 2047) begin
        ext_x = 2047;
      end
      if (ext_y > 2047) begin
        ext_y = 2047;
      end

      for (int row = 0; row < blk_h; row++) begin
        for (int col = 0; col < blk_w; col++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_item(REQ_LOAD, COORD_W'($urandom_range(0, 2047)),
                      COORD_W'($urandom_range(0, 2047)), CH_W'($urandom),
                      CH_W'($urandom), CH_W'($urandom), 1'b0, '0);
          end
          send_item(REQ_LOAD, COORD_W'(col), COORD_W'(row), CH_W'($urandom),
                    CH_W'($urandom), CH_W'($urandom), 1'b0, '0);
          rand_done = n_loads + n_requests - base_work;
          calm = (rand_done >= CALM_FROM) && (rand_done < CALM_TO);
        end
      end

      repeat (MIX_ITEMS) begin
        pick = $urandom_range(0, 99);
        found = 1'b0;
        if (pick < 70) begin
          for (tries = 0; tries < 40 && !found; tries++) begin
            rx = COORD_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, ext_x)
                                                       : $urandom_range(0, 2047));
            ry = COORD_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, ext_y)
                                                       : $urandom_range(0, 2047));
            found = pixel_ready(rx, ry);
          end
        end
        if (found) begin
          send_item(REQ_PIX, rx, ry, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom),
                    1'b0, '0);
        end else if (pick < 90) begin
          send_item(REQ_LOAD, COORD_W'($urandom_range(0, blk_w - 1)),
                    COORD_W'($urandom_range(0, blk_h - 1)), CH_W'($urandom),
                    CH_W'($urandom), CH_W'($urandom), 1'b0, '0);
        end else begin
          send_item(REQ_LOAD, COORD_W'($urandom_range(0, 2047)),
                    COORD_W'($urandom_range(0, 2047)), CH_W'($urandom),
                    CH_W'($urandom), CH_W'($urandom), 1'b0, '0);
        end
        rand_done = n_loads + n_requests - base_work;
        calm = (rand_done >= CALM_FROM) && (rand_done < CALM_TO);
      end
      phase++;
    end

    calm = 1'b0;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Coverage: %0d source loads kept, %0d dropped beyond the source size,",
             n_loads, n_dropped);
    $display("          %0d pixel requests (%0d outside) over %0d size/scale settings",
             n_requests, n_outside, n_settings);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
